[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/spmv_pkg.sv]
// ---------------------------------------------------------------------------
// spmv package
// widths, command codes and pipeline types of the sparse matrix-vector core
// ---------------------------------------------------------------------------
package spmv_pkg;

  // default sizing
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF   = 32;

  // field widths
  localparam int INDEX_BITS     = 10;
  localparam int ROW_BITS       = 10;
  localparam int ROW_COUNT_BITS = 11;
  localparam int DATA_BITS      = 32;
  localparam int CMD_BITS       = 2;
  localparam int ACC_BITS       = 64;
  localparam int FRAC_BITS      = 16;
  localparam int TDATA_BITS     = 48;

  localparam logic [ROW_COUNT_BITS-1:0] MAX_ROWS = 11'd1024;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_VEC_WRITE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_NONZERO   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLOSE_ROW = 2'd2;

  // result queue sizing
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int FIFO_PTR_BITS  = $clog2(OUT_FIFO_DEPTH);
  localparam int OCC_BITS       = FIFO_PTR_BITS + 1;

  // one input request as it travels down the pipeline
  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]  value;
    logic                  row_end;
  } spmv_item_t;

  // one closed row
  typedef struct packed {
    logic [ROW_BITS-1:0]  row_index;
    logic [DATA_BITS-1:0] row_value;
    logic                 saturated;
    logic                 last_row;
  } spmv_result_t;

endpackage

[rtl/core/csr_sparse_matrix_vector_multiply.sv]
// ---------------------------------------------------------------------------
// csr sparse matrix-vector multiply
// streaming q16.16 spmv core over a compressed-row matrix
// ---------------------------------------------------------------------------
// in_* stream: one request per handshake; in_tuser is the command (vector
//   write, nonzero, close empty row), in_tlast closes the row on a nonzero.
// out_* stream: one result per closed row with row index, saturated sum,
//   in_tuser-style flag out_tuser (saturation) and out_tlast (last row).
// cfg_* channel: row count, always ready; the user has it written while the core is idle,
//   which the block itself leaves unchecked.
// throughput: one request per cycle while in_tready is high, every command, set by the
//   single multiply and the single 64-bit accumulate in the mac stage.
// path: a closing request passes the input register, index reduction, vector read,
//   multiply, accumulate and the result queue before it raises out_tvalid.
// stall: an 8-entry result queue absorbs the pipeline; in_tready drops while
//   eight rows are in flight or queued, and for one cycle when a request
//   that closes no row takes the last free slot.
// reset: accumulator, row counter and queue clear; row count returns to
//   1024; the vector memory holds no defined value until written.
// ---------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int VALUE_BITS   = spmv_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spmv_pkg::ROW_COUNT_BITS-1:0]  cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [spmv_pkg::TDATA_BITS-1:0]      in_tdata,   // index[9:0], value[41:10]
  input  logic [spmv_pkg::CMD_BITS-1:0]        in_tuser,   // command[1:0]
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [spmv_pkg::TDATA_BITS-1:0]      out_tdata,  // row_index[9:0], row_value[41:10]
  output logic                                 out_tuser,  // saturated
  output logic                                 out_tlast
);

  localparam int OW = spmv_pkg::OCC_BITS;
  localparam int IB = spmv_pkg::INDEX_BITS;
  localparam int DB = spmv_pkg::DATA_BITS;

  logic                                 in_acc;
  logic                                 pop;
  logic                                 s0_vld_r;
  spmv_pkg::spmv_item_t                 s0_item_r;
  logic                                 s0_release;
  logic [OW-1:0]                        occ_r;
  logic [OW-1:0]                        occ_nxt;
  logic [spmv_pkg::ROW_COUNT_BITS-1:0]  row_count_r;
  logic                                 vs_vld;
  spmv_pkg::spmv_item_t                 vs_item;
  logic [VALUE_BITS-1:0]                vs_rd_data;
  logic                                 res_vld;
  spmv_pkg::spmv_result_t               res;
  spmv_pkg::spmv_result_t               head;

  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;
  assign in_tready = (occ_r < OW'(spmv_pkg::OUT_FIFO_DEPTH));
  assign cfg_ready = 1'b1;

  // requests that close no row hand their queue slot back at once
  assign s0_release = s0_vld_r &&
                      !((s0_item_r.cmd == spmv_pkg::CMD_CLOSE_ROW) ||
                        ((s0_item_r.cmd == spmv_pkg::CMD_NONZERO) && s0_item_r.row_end));
  assign occ_nxt = occ_r + OW'(in_acc) - OW'(s0_release) - OW'(pop);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      occ_r       <= '0;
      row_count_r <= spmv_pkg::MAX_ROWS;
    end else begin
      s0_vld_r <= in_acc;
      occ_r    <= occ_nxt;
      if (cfg_valid) begin
        row_count_r <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_item_r.cmd     <= in_tuser;
      s0_item_r.index   <= in_tdata[IB-1:0];
      s0_item_r.value   <= in_tdata[IB+DB-1:IB];
      s0_item_r.row_end <= in_tlast;
    end
  end

  spmv_vec_store #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .VALUE_BITS   (VALUE_BITS)
  ) u_vec_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_item  (s0_item_r),
    .out_vld  (vs_vld),
    .out_item (vs_item),
    .rd_data  (vs_rd_data)
  );

  spmv_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vs_vld),
    .in_item   (vs_item),
    .rd_data   (vs_rd_data),
    .row_count (row_count_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  spmv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (pop),
    .head_vld  (out_tvalid),
    .head_data (head)
  );

  // result packing
  assign out_tdata = {{(spmv_pkg::TDATA_BITS - IB - DB){1'b0}}, head.row_value, head.row_index};
  assign out_tuser = head.saturated;
  assign out_tlast = head.last_row;

endmodule

[rtl/core/spmv_vec_store.sv]
// ---------------------------------------------------------------------------
// spmv vector store
// index reduction modulo the depth, vector memory write and read
// ---------------------------------------------------------------------------
module spmv_vec_store #(
  parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
  parameter int VALUE_BITS   = spmv_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  spmv_pkg::spmv_item_t     in_item,
  output logic                     out_vld,
  output spmv_pkg::spmv_item_t     out_item,
  output logic [VALUE_BITS-1:0]    rd_data
);

  localparam int AW        = $clog2(VECTOR_DEPTH);
  localparam int MOD_SHIFT = 20;
  localparam int QP_BITS   = spmv_pkg::INDEX_BITS + MOD_SHIFT;
  localparam int QD_BITS   = 28;
  localparam logic [MOD_SHIFT-1:0] RECIP = MOD_SHIFT'((1 << MOD_SHIFT) / VECTOR_DEPTH);
  localparam logic [QD_BITS-1:0]   DEPTH_W = QD_BITS'(VECTOR_DEPTH);

  logic [VALUE_BITS-1:0] vec_mem [VECTOR_DEPTH];

  logic                              s1_vld_r;
  spmv_pkg::spmv_item_t              s1_item_r;
  logic [spmv_pkg::INDEX_BITS-1:0]   s1_quot_r;
  logic [QP_BITS-1:0]                quot_prod;
  logic [QD_BITS-1:0]                quot_back;
  logic [QD_BITS-1:0]                rem_raw;
  logic [QD_BITS-1:0]                rem_fix;
  logic [AW-1:0]                     addr;
  logic                              s2_vld_r;
  spmv_pkg::spmv_item_t              s2_item_r;

  // quotient estimate by reciprocal, low by at most one
  assign quot_prod = QP_BITS'(in_item.index) * QP_BITS'(RECIP);

  // remainder with a single correction step
  assign quot_back = QD_BITS'(s1_quot_r) * DEPTH_W;
  assign rem_raw   = QD_BITS'(s1_item_r.index) - quot_back;
  assign rem_fix   = (rem_raw >= DEPTH_W) ? (rem_raw - DEPTH_W) : rem_raw;
  assign addr      = rem_fix[AW-1:0];

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    s1_item_r <= in_item;
    s1_quot_r <= quot_prod[QP_BITS-1:MOD_SHIFT];
    s2_item_r <= s1_item_r;
  end

  // vector memory, writes and reads share the same stage so order holds
  always_ff @(posedge clk) begin
    if (s1_vld_r && (s1_item_r.cmd == spmv_pkg::CMD_VEC_WRITE)) begin
      vec_mem[addr] <= s1_item_r.value[VALUE_BITS-1:0];
    end
    if (s1_vld_r && (s1_item_r.cmd == spmv_pkg::CMD_NONZERO)) begin
      rd_data <= vec_mem[addr];
    end
  end

  assign out_vld  = s2_vld_r;
  assign out_item = s2_item_r;

endmodule

[rtl/core/spmv_mac.sv]
// ---------------------------------------------------------------------------
// spmv multiply-accumulate
// product, floor shift, sticky saturating accumulate, row close and clamp
// ---------------------------------------------------------------------------
module spmv_mac #(
  parameter int VALUE_BITS = spmv_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  spmv_pkg::spmv_item_t                 in_item,
  input  logic [VALUE_BITS-1:0]                rd_data,
  input  logic [spmv_pkg::ROW_COUNT_BITS-1:0]  row_count,
  output logic                                 res_vld,
  output spmv_pkg::spmv_result_t               res
);

  localparam int AB = spmv_pkg::ACC_BITS;
  localparam int PB = 2 * VALUE_BITS;
  localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
  localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] CL_HI = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] CL_LO = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic signed [VALUE_BITS-1:0]           mul_a;
  logic signed [VALUE_BITS-1:0]           mul_b;
  logic signed [PB-1:0]                   mul_p;
  logic                                   p_vld_r;
  logic [spmv_pkg::CMD_BITS-1:0]          p_cmd_r;
  logic                                   p_row_end_r;
  logic signed [PB-1:0]                   prod_r;
  logic signed [AB-1:0]                   prod_ext;
  logic signed [AB-1:0]                   term;
  logic signed [AB-1:0]                   sum;
  logic                                   ovf_pos;
  logic                                   ovf_neg;
  logic signed [AB-1:0]                   acc_add;
  logic                                   ovf_add;
  logic                                   is_nz;
  logic                                   closes;
  logic signed [AB-1:0]                   acc_new;
  logic                                   ovf_new;
  logic signed [AB-1:0]                   acc_r;
  logic signed [AB-1:0]                   acc_nxt;
  logic                                   ovf_r;
  logic                                   ovf_nxt;
  logic [spmv_pkg::ROW_BITS-1:0]          cnt_r;
  logic [spmv_pkg::ROW_BITS-1:0]          cnt_nxt;
  logic [spmv_pkg::ROW_COUNT_BITS-1:0]    eff_rows;
  logic                                   is_last;
  logic                                   r_vld_r;
  logic [spmv_pkg::ROW_BITS-1:0]          r_idx_r;
  logic signed [AB-1:0]                   r_acc_r;
  logic                                   r_ovf_r;
  logic                                   r_last_r;
  logic                                   fits;
  logic signed [VALUE_BITS-1:0]           clamp_v;

  // product stage
  assign mul_a = in_item.value[VALUE_BITS-1:0];
  assign mul_b = rd_data;
  assign mul_p = PB'(mul_a) * PB'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_cmd_r     <= in_item.cmd;
    p_row_end_r <= in_item.row_end;
    prod_r      <= mul_p;
  end

  // floor shift back to q16.16 and sticky saturating add
  assign prod_ext = AB'(prod_r);
  assign term     = prod_ext >>> spmv_pkg::FRAC_BITS;
  assign sum      = acc_r + term;
  assign ovf_pos  = !acc_r[AB-1] && !term[AB-1] && sum[AB-1];
  assign ovf_neg  = acc_r[AB-1] && term[AB-1] && !sum[AB-1];

  always_comb begin
    if (ovf_r) begin
      acc_add = acc_r;
    end else if (ovf_pos) begin
      acc_add = ACC_MAX;
    end else if (ovf_neg) begin
      acc_add = ACC_MIN;
    end else begin
      acc_add = sum;
    end
  end
  assign ovf_add = ovf_r || ovf_pos || ovf_neg;

  assign is_nz   = p_vld_r && (p_cmd_r == spmv_pkg::CMD_NONZERO);
  assign closes  = p_vld_r && ((p_cmd_r == spmv_pkg::CMD_CLOSE_ROW) ||
                               ((p_cmd_r == spmv_pkg::CMD_NONZERO) && p_row_end_r));
  assign acc_new = is_nz ? acc_add : acc_r;
  assign ovf_new = is_nz ? ovf_add : ovf_r;

  // row counter, out of range counts act as the maximum
  assign eff_rows = ((row_count == '0) || (row_count > spmv_pkg::MAX_ROWS)) ?
                    spmv_pkg::MAX_ROWS : row_count;
  assign is_last  = ({1'b0, cnt_r} >= (eff_rows - 11'd1));

  always_comb begin
    acc_nxt = acc_new;
    ovf_nxt = ovf_new;
    cnt_nxt = cnt_r;
    if (closes) begin
      acc_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = is_last ? '0 : (cnt_r + 10'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
      r_vld_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
      r_vld_r <= closes;
    end
  end

  // closed row snapshot
  always_ff @(posedge clk) begin
    if (closes) begin
      r_idx_r  <= cnt_r;
      r_acc_r  <= acc_new;
      r_ovf_r  <= ovf_new;
      r_last_r <= is_last;
    end
  end

  // clamp to the signed value range
  assign fits = (r_acc_r[AB-1:VALUE_BITS-1] == {(AB-VALUE_BITS+1){r_acc_r[AB-1]}});

  always_comb begin
    if (fits) begin
      clamp_v = r_acc_r[VALUE_BITS-1:0];
    end else if (r_acc_r[AB-1]) begin
      clamp_v = CL_LO;
    end else begin
      clamp_v = CL_HI;
    end
  end

  assign res_vld       = r_vld_r;
  assign res.row_index = r_idx_r;
  assign res.row_value = spmv_pkg::DATA_BITS'(clamp_v);
  assign res.saturated = r_ovf_r || !fits;
  assign res.last_row  = r_last_r;

endmodule

[rtl/core/spmv_out_fifo.sv]
// ---------------------------------------------------------------------------
// spmv result queue
// small register queue that decouples the pipeline from the result receiver
// ---------------------------------------------------------------------------
module spmv_out_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  spmv_pkg::spmv_result_t  push_data,
  input  logic                    pop,
  output logic                    head_vld,
  output spmv_pkg::spmv_result_t  head_data
);

  localparam int PW = spmv_pkg::FIFO_PTR_BITS;
  localparam int CW = spmv_pkg::OCC_BITS;

  spmv_pkg::spmv_result_t q_regs [spmv_pkg::OUT_FIFO_DEPTH];

  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  assign cnt_nxt = cnt_r + CW'(push) - CW'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_regs[wr_ptr_r] <= push_data;
    end
  end

  assign head_vld  = (cnt_r != '0);
  assign head_data = q_regs[rd_ptr_r];

endmodule

[rtl/core/spmv_port_checker.sv]
// ---------------------------------------------------------------------------
// spmv port checker
// port-level assertions on the spmv core, attached by bind
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spmv_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [10:0] cfg_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result stays put
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // reset empties the queue and frees the input side
  `ASSERT_CLK_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_tvalid && in_tready, "reset did not clear the result queue")

  // padding above the row value stays zero
  `ASSERT_CLK(a_out_pad, clk, rst_n, out_tvalid |-> (out_tdata[47:42] == 6'd0), "result padding not zero")

endmodule

bind csr_sparse_matrix_vector_multiply spmv_port_checker u_spmv_port_checker (.*);
